### hw/rtl/mal_pkg.sv
// ----------------------------------------------------------------------------
// mal_pkg
// Shared types, constants and helpers for the MAC address list table.
// ----------------------------------------------------------------------------
package mal_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = 48;

   // action codes
   localparam logic [2:0] ACT_ADD        = 3'd0;
   localparam logic [2:0] ACT_REMOVE     = 3'd1;
   localparam logic [2:0] ACT_QUERY      = 3'd2;
   localparam logic [2:0] ACT_REMOVE_POS = 3'd3;
   localparam logic [2:0] ACT_READ       = 3'd4;
   localparam logic [2:0] ACT_CLEAR      = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_READ,
      ST_FINISH
   } mal_state_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [ADDR_W-1:0] address;
      logic [3:0]        position;
   } mal_cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      logic [3:0]        found_position;
      logic [4:0]        entry_count;
      logic              list_full;
      logic [ADDR_W-1:0] read_address;
   } mal_result_type;

   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [ADDR_W-1:0] wr_data;
   } mal_ram_ctl_type;

   // fit an index or count into the fixed result field widths
   function automatic logic [3:0] pos_field(input logic [31:0] value);
      return value[3:0];
   endfunction

   function automatic logic [4:0] count_field(input logic [31:0] value);
      return value[4:0];
   endfunction

endpackage

### hw/rtl/mal_req_if.sv
// ----------------------------------------------------------------------------
// mal_req_if
// Command channel: valid/ready handshake with action, address and position.
// ----------------------------------------------------------------------------
interface mal_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [47:0] address;
   logic [3:0]  position;

   modport source (output valid, output action, output address, output position,
                   input ready);
   modport sink   (input valid, input action, input address, input position,
                   output ready);
endinterface

### hw/rtl/mal_rsp_if.sv
// ----------------------------------------------------------------------------
// mal_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface mal_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        found;
   logic [3:0]  found_position;
   logic [4:0]  entry_count;
   logic        list_full;
   logic [47:0] read_address;

   modport source (output valid, output status, output found, output found_position,
                   output entry_count, output list_full, output read_address,
                   input ready);
   modport sink   (input valid, input status, input found, input found_position,
                   input entry_count, input list_full, input read_address,
                   output ready);
endinterface

### hw/rtl/mal_ram.sv
// ----------------------------------------------------------------------------
// mal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mal_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mal_ctrl.sv
// ----------------------------------------------------------------------------
// mal_ctrl
// Sequencer: sweeps the entry RAM through one read port and one comparator
// for lookups, and compacts the list after a removal.
// ----------------------------------------------------------------------------
module mal_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mal_pkg::mal_cmd_type                req_cmd,
   output logic                                done,
   input  logic                                done_ack,
   output mal_pkg::mal_result_type             result,
   output mal_pkg::mal_ram_ctl_type            ram_ctl,
   input  logic [mal_pkg::ADDR_W-1:0]          ram_rd_data
);
   import mal_pkg::*;

   mal_state_type   state_ff, state_in;
   mal_cmd_type     cmd_ff, cmd_in;
   mal_result_type  res_ff, res_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_valid_ff, cmp_valid_in;

   logic hit, issue_avail, sweep_done, pos_ok, list_at_max;

   assign req_ready   = (state_ff == ST_IDLE);
   assign hit         = cmp_valid_ff && (ram_rd_data == cmd_ff.address);
   assign issue_avail = (rd_idx_ff < count_ff);
   assign sweep_done  = !cmp_valid_ff && !issue_avail;
   assign pos_ok      = (32'(req_cmd.position) < 32'(count_ff));
   assign list_at_max = (32'(count_ff) == 32'(MAX_ENTRIES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd.action) inside
                  ACT_ADD, ACT_REMOVE, ACT_QUERY: state_in = ST_SEARCH;
                  ACT_REMOVE_POS: state_in = pos_ok ? ST_SHIFT : ST_FINISH;
                  ACT_READ:       state_in = pos_ok ? ST_READ : ST_FINISH;
                  default:        state_in = ST_FINISH;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = (cmd_ff.action == ACT_REMOVE) ? ST_SHIFT : ST_FINISH;
            end else if (sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT:  if (sweep_done) state_in = ST_FINISH;
         ST_READ:   state_in = ST_FINISH;
         ST_FINISH: if (done_ack) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      ram_ctl         = '0;
      ram_ctl.rd_addr = rd_idx_ff[IDX_W-1:0];
      ram_ctl.wr_data = ram_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               res_in         = '0;
               res_in.status  = STATUS_MISS;
               rd_idx_in      = '0;
               cmp_valid_in   = 1'b0;
               unique case (req_cmd.action)
                  ACT_REMOVE_POS: begin
                     if (pos_ok) begin
                        res_in.status         = STATUS_OK;
                        res_in.found_position = req_cmd.position;
                        rd_idx_in             = CNT_W'(req_cmd.position) + CNT_W'(1);
                     end
                  end
                  ACT_READ: begin
                     if (pos_ok) begin
                        ram_ctl.rd_en         = 1'b1;
                        ram_ctl.rd_addr       = IDX_W'(req_cmd.position);
                        res_in.status         = STATUS_OK;
                        res_in.found_position = req_cmd.position;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in      = '0;
                     res_in.status = STATUS_OK;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               res_in.status         = STATUS_OK;
               res_in.found          = 1'b1;
               res_in.found_position = pos_field(32'(cmp_idx_ff));
               cmp_valid_in          = 1'b0;
               rd_idx_in             = CNT_W'(cmp_idx_ff) + CNT_W'(1);
            end else if (sweep_done) begin
               if (cmd_ff.action == ACT_ADD) begin
                  if (list_at_max) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     ram_ctl.wr_en         = 1'b1;
                     ram_ctl.wr_addr       = count_ff[IDX_W-1:0];
                     ram_ctl.wr_data       = cmd_ff.address;
                     res_in.status         = STATUS_OK;
                     res_in.found_position = pos_field(32'(count_ff));
                     count_in              = count_ff + CNT_W'(1);
                  end
               end
            end else begin
               ram_ctl.rd_en = issue_avail;
               if (issue_avail) rd_idx_in = rd_idx_ff + CNT_W'(1);
               cmp_valid_in  = issue_avail;
               cmp_idx_in    = rd_idx_ff[IDX_W-1:0];
            end
         end
         ST_SHIFT: begin
            // read entry i+2 while the previous read, entry i+1, lands in entry i
            if (cmp_valid_ff) begin
               ram_ctl.wr_en   = 1'b1;
               ram_ctl.wr_addr = cmp_idx_ff - IDX_W'(1);
            end
            ram_ctl.rd_en = issue_avail;
            if (issue_avail) rd_idx_in = rd_idx_ff + CNT_W'(1);
            cmp_valid_in  = issue_avail;
            cmp_idx_in    = rd_idx_ff[IDX_W-1:0];
            if (sweep_done) count_in = count_ff - CNT_W'(1);
         end
         ST_READ:   res_in.read_address = ram_rd_data;
         ST_FINISH: ;
         default:   ;
      endcase
   end

   always_comb begin
      result             = res_ff;
      result.entry_count = count_field(32'(count_ff));
      result.list_full   = list_at_max;
   end

   assign done = (state_ff == ST_FINISH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_ENTRIES))
      else $error("entry count above capacity");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> 32'(ram_ctl.wr_addr) <= 32'(count_ff))
      else $error("RAM write beyond list end");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      done && (result.status == STATUS_FULL) |-> result.list_full)
      else $error("full status on a list that is not full");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      done && result.found |-> result.status == STATUS_OK)
      else $error("found with non-ok status");

   a_shift_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && sweep_done |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("removal did not shrink the list");

endmodule

### hw/rtl/mac_address_list_table_top.sv
// ----------------------------------------------------------------------------
// mac_address_list_table_top
// Insertion-ordered list of up to MAX_ENTRIES 48-bit MAC addresses.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Every action that touches the entries
// goes through a single entry RAM with one read and one write port, so the
// time for a sweep follows the list length n. Add, remove by address and
// query sweep the entries one per cycle with one shared 48-bit comparator.
// A removal then compacts the list, moving one entry per cycle. With 16
// entries the slowest case is a remove by address that hits the head: a
// sweep of one entry plus a compaction of 15. A stalled result adds its
// stall on top. The result sits in an output register, so a new transaction
// is taken while the previous result waits to be collected. Entry storage is
// not cleared at reset; only entries below the count are ever read, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module mac_address_list_table_top (
   input  logic      clock,
   input  logic      reset,
   mal_req_if.sink   req_chan,
   mal_rsp_if.source rsp_chan
);
   import mal_pkg::*;

   mal_cmd_type      req_cmd;
   mal_result_type   result;
   mal_ram_ctl_type  ram_ctl;
   logic [ADDR_W-1:0] ram_rd_data;
   logic             done, done_ack, slot_free;

   // output register
   mal_result_type   rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_cmd.action   = req_chan.action;
   assign req_cmd.address  = req_chan.address;
   assign req_cmd.position = req_chan.position;

   mal_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_cmd     (req_cmd),
      .done        (done),
      .done_ack    (done_ack),
      .result      (result),
      .ram_ctl     (ram_ctl),
      .ram_rd_data (ram_rd_data)
   );

   mal_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // the sequencer holds its result until the output register can take it
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign done_ack  = done && slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = done;
         if (done) rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.found          = rsp_data_ff.found;
   assign rsp_chan.found_position = rsp_data_ff.found_position;
   assign rsp_chan.entry_count    = rsp_data_ff.entry_count;
   assign rsp_chan.list_full      = rsp_data_ff.list_full;
   assign rsp_chan.read_address   = rsp_data_ff.read_address;

endmodule
